// File: rtl/fs_pkg.sv
`timescale 1ns / 1ps
// fs_pkg: shared types and helpers of the fraction sorter
// item and result structs, sort key, link between cells, exact fraction compare
package fs_pkg;

	typedef struct packed {
		logic signed [31:0] numerator;
		logic signed [31:0] denominator;
		logic               last_item;
	} fs_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_numerator;
		logic signed [31:0] sorted_denominator;
		logic               end_of_run;
		logic               overflowed;
	} fs_result_t;

	// original fraction plus a copy with the denominator made positive
	typedef struct packed {
		logic signed [31:0] num;
		logic signed [31:0] den;
		logic signed [32:0] norm_num;
		logic        [31:0] norm_den;
		logic               den_zero;
	} fs_key_t;

	// what a cell shows its neighbors
	typedef struct packed {
		logic    valid;
		logic    moves;
		fs_key_t key;
	} fs_link_t;

	typedef struct packed {
		logic insert;
		logic drain;
	} fs_ctl_t;

	function automatic fs_key_t fs_make_key(logic signed [31:0] num, logic signed [31:0] den);
		fs_key_t          k;
		logic signed [32:0] den_neg;
		k.num      = num;
		k.den      = den;
		k.den_zero = (den == 32'sd0);
		den_neg    = -$signed({den[31], den});
		if (den[31]) begin
			k.norm_num = -$signed({num[31], num});
			k.norm_den = den_neg[31:0];
		end else begin
			k.norm_num = $signed({num[31], num});
			k.norm_den = den;
		end
		return k;
	endfunction

	// true if a is strictly smaller than b; zero denominator sorts last
	function automatic logic fs_less(fs_key_t a, fs_key_t b);
		logic signed [65:0] lhs;
		logic signed [65:0] rhs;
		lhs = a.norm_num * $signed({1'b0, b.norm_den});
		rhs = b.norm_num * $signed({1'b0, a.norm_den});
		return !a.den_zero && (b.den_zero || (lhs < rhs));
	endfunction

endpackage

// File: rtl/fs_cell.sv
`timescale 1ns / 1ps
// fs_cell: one slot of the insertion sort chain
// depends on fs_pkg (key, link and control types, fs_less)
module fs_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  fs_pkg::fs_ctl_t  ctl,
	input  fs_pkg::fs_key_t  new_key,
	input  fs_pkg::fs_link_t prev,
	input  fs_pkg::fs_link_t next,
	output fs_pkg::fs_link_t link
);
	import fs_pkg::*;

	logic    valid_q;
	fs_key_t key_q;
	logic    moves;

	// stored entry gives way when the new key is strictly smaller (stable on ties)
	assign moves = valid_q && fs_less(new_key, key_q);

	assign link.valid = valid_q;
	assign link.moves = moves;
	assign link.key   = key_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.drain) begin
			valid_q <= next.valid;
		end else if (ctl.insert && !valid_q && prev.valid) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.drain) begin
			key_q <= next.key;
		end else if (ctl.insert) begin
			if (moves || (!valid_q && prev.valid)) begin
				key_q <= prev.moves ? prev.key : new_key;
			end
		end
	end

endmodule

// File: rtl/fraction_sorter.sv
`timescale 1ns / 1ps
// fraction_sorter: stable ascending sort of signed fractions in a chain of cells
// the last item passes the input register, then the drain flag, then the result register before the first result shows
// throughput: one item per cycle while loading, then the results of the set in order;
// busy holds from the last item until the final result is shown
// reset clears every cell's valid bit, the item count and the drop flag
// results carry a one-cycle strobe and cannot be held off by the receiver
module fraction_sorter #(
	parameter int CAPACITY = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  fs_pkg::fs_item_t   fraction,
	output logic               result_valid,
	output fs_pkg::fs_result_t result
);
	import fs_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	// input register: one item, already in key form
	logic    s1_valid_q;
	logic    s1_keep_q;
	logic    s1_last_q;
	fs_key_t key_s1;

	// set bookkeeping
	logic [CW-1:0] count_q;
	logic          drop_q;
	logic          drain_q;
	logic [CW-1:0] rem_q;
	logic          run_drop_q;

	// result register
	logic       res_valid_q;
	fs_result_t res_q;

	logic     accept;
	logic     keep;
	fs_ctl_t  ctl;
	fs_link_t links [CAPACITY];
	fs_link_t head;
	fs_link_t tail;

	assign accept = start && !busy;
	assign keep   = (count_q < CW'(CAPACITY));

	// busy once the last item is in, until the final result is shown
	assign busy = (s1_valid_q && s1_last_q) || drain_q;

	assign ctl.insert = s1_valid_q && s1_keep_q;
	assign ctl.drain  = drain_q;

	// cell 0 sees a full neighbor that never moves; the final cell drains in empties
	assign head.valid = 1'b1;
	assign head.moves = 1'b0;
	assign head.key   = '0;
	assign tail.valid = 1'b0;
	assign tail.moves = 1'b0;
	assign tail.key   = '0;

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			fs_link_t prev_l;
			fs_link_t next_l;
			if (gi == 0) begin : g_first
				assign prev_l = head;
			end else begin : g_mid_prev
				assign prev_l = links[gi-1];
			end
			if (gi == CAPACITY - 1) begin : g_end
				assign next_l = tail;
			end else begin : g_mid_next
				assign next_l = links[gi+1];
			end
			fs_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctl     (ctl),
				.new_key (key_s1),
				.prev    (prev_l),
				.next    (next_l),
				.link    (links[gi])
			);
		end
	endgenerate

	// input stage: items past capacity ride along only to mark the drop and the end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s1_keep_q  <= 1'b0;
			s1_last_q  <= 1'b0;
		end else begin
			s1_valid_q <= accept;
			s1_keep_q  <= accept && keep;
			s1_last_q  <= accept && fraction.last_item;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			key_s1 <= fs_make_key(fraction.numerator, fraction.denominator);
		end
	end

	// count, drop flag and drain sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			drop_q      <= 1'b0;
			drain_q     <= 1'b0;
			rem_q       <= '0;
			run_drop_q  <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= drain_q;
			if (accept) begin
				if (keep) begin
					count_q <= count_q + CW'(1);
				end else begin
					drop_q <= 1'b1;
				end
			end
			if (s1_valid_q && s1_last_q) begin
				// last item goes into the chain this edge unless it was dropped; the set is closed
				drain_q    <= 1'b1;
				rem_q      <= count_q;
				run_drop_q <= drop_q;
				count_q    <= '0;
				drop_q     <= 1'b0;
			end else if (drain_q) begin
				rem_q <= rem_q - CW'(1);
				if (rem_q == CW'(1)) begin
					drain_q <= 1'b0;
				end
			end
		end
	end

	// cell 0 always holds the smallest remaining fraction
	always_ff @(posedge clk) begin
		if (drain_q) begin
			res_q.sorted_numerator   <= links[0].key.num;
			res_q.sorted_denominator <= links[0].key.den;
			res_q.end_of_run         <= (rem_q == CW'(1));
			res_q.overflowed         <= run_drop_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// the stored count never passes the chain length
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("item count beyond capacity");

	// while draining, the head of the chain holds a fraction
	a_drain_head: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> links[0].valid)
		else $error("drain with empty head cell");

	// the final result of a set is followed by a quiet cycle
	a_end_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.end_of_run) |=> !result_valid)
		else $error("result after end of run");

	// a drained chain is empty
	a_empty_after: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.end_of_run) |-> !links[0].valid)
		else $error("cells left valid after drain");

endmodule
